### hw/rtl/touchpad_event_filter_assert.svh
// ----------------------------------------------------------------------------
// Touchpad event filter assertion macros
// Shared property forms for the checker of the filter's ports.
// ----------------------------------------------------------------------------
`ifndef TOUCHPAD_EVENT_FILTER_ASSERT_SVH
`define TOUCHPAD_EVENT_FILTER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define TEF_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define TEF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hw/rtl/tef_pkg.sv
// ----------------------------------------------------------------------------
// Touchpad event filter package
// Sizes, event codes, register indexes and shared control types.
// ----------------------------------------------------------------------------
package tef_pkg;

	localparam int SLOT_COUNT = 10;
	localparam int POS_BITS   = 16;
	localparam int FRAC_BITS  = 8;

	localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int CNT_W  = $clog2(SLOT_COUNT + 1);
	localparam int SUM_W  = POS_BITS + CNT_W;
	localparam int DIV_W  = SUM_W;
	localparam int DVS_W  = (CNT_W > 4) ? CNT_W : 4;
	localparam int SM_W   = POS_BITS + FRAC_BITS;
	localparam int WT_W   = FRAC_BITS + 1;
	localparam int PROD_W = SM_W + WT_W;

	localparam logic [WT_W-1:0] ONE_Q   = WT_W'(1 << FRAC_BITS);
	localparam logic [WT_W-1:0] W_HEAVY = WT_W'((3 * (1 << FRAC_BITS) + 5) / 10);
	localparam logic [WT_W-1:0] W_MOD   = WT_W'((6 * (1 << FRAC_BITS) + 5) / 10);
	localparam logic [WT_W-1:0] W_LIGHT = WT_W'((85 * (1 << FRAC_BITS) + 50) / 100);

	// Wheel amount: floor(x / 10) as (x * 52429) >> 19, exact for x below 2^18.
	localparam int AMT_W        = POS_BITS + 2;
	localparam int RECIP_W      = 16;
	localparam int AMT_PROD_W   = AMT_W + RECIP_W;
	localparam int DIV10_SHIFT  = 19;
	localparam int AMT_Q_W      = AMT_PROD_W - DIV10_SHIFT;
	localparam logic [RECIP_W-1:0] DIV10_RECIP = 16'd52429;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 8;
	localparam logic [CFG_IDX_W-1:0] CFG_PASSTHROUGH = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CALIBRATION = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DEADZONE    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SMALL_MOVE  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_MEDIUM_MOVE = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_LIFT_JUMP   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_SCROLL_MIN  = 3'd6;

	localparam logic [15:0] T_SYN = 16'd0;
	localparam logic [15:0] T_KEY = 16'd1;
	localparam logic [15:0] T_REL = 16'd2;
	localparam logic [15:0] T_ABS = 16'd3;
	localparam logic [15:0] T_MSC = 16'd4;

	localparam logic [15:0] C_REPORT    = 16'h0000;
	localparam logic [15:0] C_BTN_TOUCH = 16'h014A;
	localparam logic [15:0] C_REL_X     = 16'h0000;
	localparam logic [15:0] C_REL_Y     = 16'h0001;
	localparam logic [15:0] C_WHEEL     = 16'h0008;
	localparam logic [15:0] C_ABS_X     = 16'h0000;
	localparam logic [15:0] C_ABS_Y     = 16'h0001;
	localparam logic [15:0] C_MT_SLOT   = 16'h002F;
	localparam logic [15:0] C_MT_MAJOR  = 16'h0030;
	localparam logic [15:0] C_MT_MINOR  = 16'h0031;
	localparam logic [15:0] C_MT_PX     = 16'h0035;
	localparam logic [15:0] C_MT_PY     = 16'h0036;
	localparam logic [15:0] C_MT_TRACK  = 16'h0039;
	localparam logic [15:0] C_MT_PRESS  = 16'h003A;

	typedef struct packed {
		logic             start;
		logic [DIV_W-1:0] dividend;
		logic [DVS_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [DIV_W-1:0] quotient;
	} div_rsp_t;

endpackage

### hw/rtl/tef_if.sv
// ----------------------------------------------------------------------------
// Touchpad event filter channels
// Valid/ready channels for incoming events and for filtered results.
// ----------------------------------------------------------------------------
interface tef_ev_if;
	logic               valid;
	logic               ready;
	logic [15:0]        ev_type;
	logic [15:0]        ev_code;
	logic signed [31:0] ev_value;

	modport source (output valid, output ev_type, output ev_code, output ev_value,
		input ready);
	modport sink (input valid, input ev_type, input ev_code, input ev_value,
		output ready);
endinterface

interface tef_res_if;
	logic               valid;
	logic               ready;
	logic [15:0]        out_type;
	logic [15:0]        out_code;
	logic signed [31:0] out_value;
	logic               out_last;

	modport source (output valid, output out_type, output out_code, output out_value,
		output out_last, input ready);
	modport sink (input valid, input out_type, input out_code, input out_value,
		input out_last, output ready);
endinterface

### hw/rtl/touchpad_event_filter.sv
// ----------------------------------------------------------------------------
// Touchpad event filter
// Filters touchpad input events: slot tracking, two-finger scroll to wheel
// events, one-finger deadzone, lift rejection and exponential smoothing.
// ----------------------------------------------------------------------------
//  channel | direction | payload                                   | handshake
//  ev      | in        | ev_type, ev_code, ev_value                | valid/ready
//  res     | out       | out_type, out_code, out_value, out_last   | valid/ready
//  cfg     | in        | cfg_index, cfg_data                       | cfg_we only
//
// A request that passes straight through goes from decode to emit. A first
// touch also passes the smoothing check, a smoothed position then takes two
// multiply steps and an update, and a two-finger Y update sweeps every slot
// and waits for the bit-serial divider. One result register sits on the output,
// so the next request is taken while a result waits. While a second result is
// due, the block waits for the output register to drain. arst_n clears all
// tracking state and loads the register defaults.
// ----------------------------------------------------------------------------
module touchpad_event_filter (
	input  logic                                clk,
	input  logic                                arst_n,
	tef_ev_if.sink                              ev,
	tef_res_if.source                           res,
	input  logic                                cfg_we,
	input  logic [tef_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [tef_pkg::CFG_DATA_W-1:0]      cfg_data
);
	import tef_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_DECODE, S_SUM, S_AVG_GO, S_AVG_WAIT, S_AMT_MUL, S_AMT_SET,
		S_SM_CHK, S_SM_MUL1, S_SM_MUL2, S_SM_UPD, S_EMIT, S_EMIT2
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic       passthrough_q;
	logic       calibration_q;
	logic [7:0] deadzone_q;
	logic [7:0] small_move_q;
	logic [7:0] medium_move_q;
	logic [7:0] lift_jump_q;
	logic [7:0] scroll_min_q;

	// Latched request.
	logic [15:0]        type_q;
	logic [15:0]        code_q;
	logic signed [31:0] val_q;

	// Slot and finger tracking.
	logic [SLOT_COUNT-1:0] slot_busy_q;
	logic [POS_BITS-1:0]   slot_y_q [SLOT_COUNT];
	logic [SLOT_W-1:0]     cur_slot_q;
	logic [CNT_W-1:0]      finger_cnt_q;
	logic [CNT_W-1:0]      prior_cnt_q;
	logic [CNT_W-1:0]      settled_q;
	logic                  ref_valid_q;
	logic [POS_BITS-1:0]   ref_y_q;

	// Scroll sweep.
	logic [SLOT_W-1:0]   sweep_q;
	logic [SUM_W-1:0]    sum_q;
	logic [CNT_W-1:0]    busy_n_q;
	logic [POS_BITS-1:0] mag_q;
	logic                up_q;
	logic [AMT_Q_W-1:0]  amt_q;

	// Axis smoothing.
	logic [SM_W-1:0]           axis_sm_q   [2];
	logic [1:0]                axis_valid_q;
	logic [POS_BITS-1:0]       axis_last_q [2];
	logic signed [POS_BITS:0]  axis_prev_q [2];
	logic                      ax_q;
	logic [POS_BITS-1:0]       pos_q;
	logic [WT_W-1:0]           wt_q;
	logic signed [POS_BITS:0]  step_q;
	logic [PROD_W-1:0]         prod1_q;
	logic [PROD_W-1:0]         prod2_q;

	// Pending result; em_two_q appends a report sync event after it.
	logic [15:0] em_type_q;
	logic [15:0] em_code_q;
	logic [31:0] em_val_q;
	logic        em_two_q;

	// Output register.
	logic               res_valid_q;
	logic [15:0]        res_type_q;
	logic [15:0]        res_code_q;
	logic signed [31:0] res_val_q;
	logic               res_last_q;

	div_req_t div_req;
	div_rsp_t div_rsp;

	tef_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	function automatic logic [POS_BITS-1:0] clamp_pos(input logic signed [31:0] v);
		if (v < 0)
			return '0;
		else if (v > 32'sd0 + ((1 << POS_BITS) - 1))
			return '1;
		else
			return v[POS_BITS-1:0];
	endfunction

	function automatic logic [SLOT_W-1:0] clamp_slot(input logic signed [31:0] v);
		if (v < 0)
			return '0;
		else if (v >= SLOT_COUNT)
			return SLOT_W'(SLOT_COUNT - 1);
		else
			return v[SLOT_W-1:0];
	endfunction

	function automatic logic is_mt(input logic [15:0] c);
		return c == C_MT_SLOT || c == C_MT_TRACK || c == C_MT_PX || c == C_MT_PY ||
			c == C_MT_MAJOR || c == C_MT_MINOR || c == C_MT_PRESS;
	endfunction

	logic out_free;
	logic ev_fire;
	assign out_free = !res_valid_q || res.ready;
	assign ev.ready = state_q == S_IDLE;
	assign ev_fire  = ev.valid && ev.ready;

	// Decode helpers for the latched request.
	logic [CNT_W-1:0] cnt_after_lift;
	logic             is_pos_code;
	logic [31:0]      cal_val;
	assign cnt_after_lift = slot_busy_q[cur_slot_q] ? finger_cnt_q - 1'b1 : finger_cnt_q;
	assign is_pos_code = code_q == C_ABS_X || code_q == C_ABS_Y || code_q == C_MT_PX ||
		code_q == C_MT_PY;
	assign cal_val = (val_q == -32'sd1) ? 32'd0 : 32'(val_q) + 32'd1;

	// Scroll arithmetic.
	logic signed [POS_BITS:0] avg_diff;
	logic [POS_BITS-1:0]      avg_new;
	logic [POS_BITS-1:0]      avg_mag;
	assign avg_new  = div_rsp.quotient[POS_BITS-1:0];
	assign avg_diff = $signed({1'b0, avg_new}) - $signed({1'b0, ref_y_q});
	assign avg_mag  = avg_diff[POS_BITS] ? POS_BITS'(-avg_diff) : avg_diff[POS_BITS-1:0];

	// Wheel amount (3*|d| + 5) / 10 by reciprocal multiplication.
	logic [AMT_W-1:0]      amt_num;
	logic [AMT_PROD_W-1:0] amt_prod;
	assign amt_num  = AMT_W'({mag_q, 1'b0}) + AMT_W'(mag_q) + AMT_W'(5);
	assign amt_prod = AMT_PROD_W'(amt_num) * AMT_PROD_W'(DIV10_RECIP);

	always_comb begin
		div_req.start    = state_q == S_AVG_GO && busy_n_q != '0;
		div_req.dividend = sum_q;
		div_req.divisor  = DVS_W'(busy_n_q);
	end

	// Smoothing step checks.
	logic signed [POS_BITS:0] sm_step;
	logic [POS_BITS-1:0]      sm_mag;
	logic [POS_BITS-1:0]      prev_mag;
	logic signed [POS_BITS:0] prev_step;
	assign sm_step   = $signed({1'b0, pos_q}) - $signed({1'b0, axis_last_q[ax_q]});
	assign sm_mag    = sm_step[POS_BITS] ? POS_BITS'(-sm_step) : sm_step[POS_BITS-1:0];
	assign prev_step = axis_prev_q[ax_q];
	assign prev_mag  = prev_step[POS_BITS] ? POS_BITS'(-prev_step) : prev_step[POS_BITS-1:0];

	// Shared multiplier: new-sample term, then old-average term.
	logic [WT_W-1:0]   mul_a;
	logic [SM_W-1:0]   mul_b;
	logic [PROD_W-1:0] mul_p;
	logic [PROD_W:0]   upd_sum;
	logic [SM_W-1:0]   sm_new;
	logic [SM_W:0]     sm_round;
	assign mul_a    = (state_q == S_SM_MUL1) ? wt_q : ONE_Q - wt_q;
	assign mul_b    = (state_q == S_SM_MUL1) ? {pos_q, {FRAC_BITS{1'b0}}} : axis_sm_q[ax_q];
	assign mul_p    = PROD_W'(mul_a) * PROD_W'(mul_b);
	assign upd_sum  = (PROD_W + 1)'(prod1_q) + (PROD_W + 1)'(prod2_q)
		+ (PROD_W + 1)'(ONE_Q >> 1);
	assign sm_new   = upd_sum[SM_W+FRAC_BITS-1:FRAC_BITS];
	assign sm_round = (SM_W + 1)'(sm_new) + (SM_W + 1)'(ONE_Q >> 1);

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			passthrough_q <= 1'b1;
			calibration_q <= 1'b0;
			deadzone_q    <= 8'd2;
			small_move_q  <= 8'd10;
			medium_move_q <= 8'd25;
			lift_jump_q   <= 8'd15;
			scroll_min_q  <= 8'd3;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_PASSTHROUGH: passthrough_q <= cfg_data[0];
				CFG_CALIBRATION: calibration_q <= cfg_data[0];
				CFG_DEADZONE:    deadzone_q    <= cfg_data;
				CFG_SMALL_MOVE:  small_move_q  <= cfg_data;
				CFG_MEDIUM_MOVE: medium_move_q <= cfg_data;
				CFG_LIFT_JUMP:   lift_jump_q   <= cfg_data;
				CFG_SCROLL_MIN:  scroll_min_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Sequencer with all tracking state and the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			slot_busy_q  <= '0;
			for (int i = 0; i < SLOT_COUNT; i++)
				slot_y_q[i] <= '0;
			cur_slot_q   <= '0;
			finger_cnt_q <= '0;
			prior_cnt_q  <= '0;
			settled_q    <= '0;
			ref_valid_q  <= 1'b0;
			ref_y_q      <= '0;
			axis_valid_q <= '0;
			for (int i = 0; i < 2; i++) begin
				axis_sm_q[i]   <= '0;
				axis_last_q[i] <= '0;
				axis_prev_q[i] <= '0;
			end
			res_valid_q  <= 1'b0;
		end else begin
			if (res_valid_q && res.ready)
				res_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (ev_fire) begin
						type_q <= ev.ev_type;
						code_q <= ev.ev_code;
						val_q  <= ev.ev_value;
						// A report sync event settles the finger count even when paused.
						if (ev.ev_type == T_SYN && ev.ev_code == C_REPORT) begin
							if (finger_cnt_q != prior_cnt_q) begin
								ref_valid_q <= 1'b0;
								prior_cnt_q <= finger_cnt_q;
							end
							settled_q <= finger_cnt_q;
						end
						state_q <= S_DECODE;
					end
				end
				S_DECODE: begin
					em_type_q <= type_q;
					em_code_q <= code_q;
					em_val_q  <= 32'(val_q);
					em_two_q  <= 1'b0;
					state_q   <= S_EMIT;
					if (!passthrough_q) begin
						state_q <= S_IDLE;
					end else begin
						case (type_q)
							T_KEY: begin
								// Finger lift restarts the smoothing of both axes.
								if (val_q == 0 && code_q == C_BTN_TOUCH) begin
									axis_valid_q <= '0;
									for (int i = 0; i < 2; i++) begin
										axis_sm_q[i]   <= '0;
										axis_last_q[i] <= '0;
										axis_prev_q[i] <= '0;
									end
								end
							end
							T_REL: begin
								if (code_q != C_REL_X && code_q != C_REL_Y)
									state_q <= S_IDLE;
								else if (calibration_q)
									em_val_q <= cal_val;
							end
							T_ABS: begin
								if (code_q == C_MT_SLOT)
									cur_slot_q <= clamp_slot(val_q);
								if (code_q == C_MT_TRACK) begin
									if (val_q == -32'sd1) begin
										finger_cnt_q <= cnt_after_lift;
										slot_busy_q[cur_slot_q] <= 1'b0;
										if (cnt_after_lift == '0)
											ref_valid_q <= 1'b0;
									end else begin
										if (!slot_busy_q[cur_slot_q])
											finger_cnt_q <= finger_cnt_q + 1'b1;
										slot_busy_q[cur_slot_q] <= 1'b1;
									end
								end
								if (code_q == C_MT_PY)
									slot_y_q[cur_slot_q] <= clamp_pos(val_q);
								pos_q <= clamp_pos(val_q);
								ax_q  <= !(code_q == C_ABS_X || code_q == C_MT_PX);
								if (code_q == C_MT_PY && settled_q == CNT_W'(2)) begin
									sweep_q  <= '0;
									sum_q    <= '0;
									busy_n_q <= '0;
									state_q  <= S_SUM;
								end else if (settled_q >= CNT_W'(2)) begin
									if (is_mt(code_q))
										state_q <= S_IDLE;
								end else if (settled_q == CNT_W'(1) && is_pos_code) begin
									state_q <= S_SM_CHK;
								end
							end
							default: ;
						endcase
					end
				end
				S_SUM: begin
					if (slot_busy_q[sweep_q]) begin
						sum_q    <= sum_q + SUM_W'(slot_y_q[sweep_q]);
						busy_n_q <= busy_n_q + 1'b1;
					end
					sweep_q <= sweep_q + 1'b1;
					if (sweep_q == SLOT_W'(SLOT_COUNT - 1))
						state_q <= S_AVG_GO;
				end
				S_AVG_GO: begin
					state_q <= (busy_n_q == '0) ? S_IDLE : S_AVG_WAIT;
				end
				S_AVG_WAIT: begin
					if (div_rsp.done) begin
						ref_y_q     <= avg_new;
						ref_valid_q <= 1'b1;
						mag_q       <= avg_mag;
						up_q        <= !avg_diff[POS_BITS] && avg_diff != '0;
						if (ref_valid_q && avg_mag > POS_BITS'(scroll_min_q))
							state_q <= S_AMT_MUL;
						else
							state_q <= S_IDLE;
					end
				end
				S_AMT_MUL: begin
					amt_q   <= amt_prod[AMT_PROD_W-1:DIV10_SHIFT];
					state_q <= S_AMT_SET;
				end
				S_AMT_SET: begin
					em_type_q <= T_REL;
					em_code_q <= C_WHEEL;
					em_val_q  <= up_q ? -32'(amt_q) : 32'(amt_q);
					em_two_q  <= 1'b1;
					state_q   <= (amt_q == '0) ? S_IDLE : S_EMIT;
				end
				S_SM_CHK: begin
					em_type_q <= T_ABS;
					em_code_q <= code_q;
					em_two_q  <= 1'b0;
					step_q    <= sm_step;
					if (!axis_valid_q[ax_q]) begin
						// First touch seeds the average with the raw position.
						axis_valid_q[ax_q] <= 1'b1;
						axis_sm_q[ax_q]    <= {pos_q, {FRAC_BITS{1'b0}}};
						axis_last_q[ax_q]  <= pos_q;
						em_val_q           <= 32'(pos_q);
						state_q            <= S_EMIT;
					end else if (sm_mag < POS_BITS'(deadzone_q)) begin
						state_q <= S_IDLE;
					end else if (sm_mag > POS_BITS'(lift_jump_q) &&
							prev_mag < POS_BITS'(small_move_q)) begin
						state_q <= S_IDLE;
					end else begin
						if (sm_mag < POS_BITS'(small_move_q))
							wt_q <= W_HEAVY;
						else if (sm_mag < POS_BITS'(medium_move_q))
							wt_q <= W_MOD;
						else
							wt_q <= W_LIGHT;
						state_q <= S_SM_MUL1;
					end
				end
				S_SM_MUL1: begin
					prod1_q <= mul_p;
					state_q <= S_SM_MUL2;
				end
				S_SM_MUL2: begin
					prod2_q <= mul_p;
					state_q <= S_SM_UPD;
				end
				S_SM_UPD: begin
					axis_sm_q[ax_q]   <= sm_new;
					axis_last_q[ax_q] <= pos_q;
					axis_prev_q[ax_q] <= step_q;
					em_val_q          <= 32'(sm_round[SM_W:FRAC_BITS]);
					state_q           <= S_EMIT;
				end
				S_EMIT: begin
					if (out_free) begin
						res_valid_q <= 1'b1;
						res_type_q  <= em_type_q;
						res_code_q  <= em_code_q;
						res_val_q   <= em_val_q;
						res_last_q  <= !em_two_q;
						state_q     <= em_two_q ? S_EMIT2 : S_IDLE;
					end
				end
				S_EMIT2: begin
					if (out_free) begin
						res_valid_q <= 1'b1;
						res_type_q  <= T_SYN;
						res_code_q  <= C_REPORT;
						res_val_q   <= '0;
						res_last_q  <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign res.valid     = res_valid_q;
	assign res.out_type  = res_type_q;
	assign res.out_code  = res_code_q;
	assign res.out_value = res_val_q;
	assign res.out_last  = res_last_q;
endmodule

### hw/rtl/tef_div.sv
// ----------------------------------------------------------------------------
// Touchpad event filter divider
// Restoring divider, one quotient bit per cycle, shared by all divisions.
// ----------------------------------------------------------------------------
module tef_div (
	input  logic              clk,
	input  logic              arst_n,
	input  tef_pkg::div_req_t req,
	output tef_pkg::div_rsp_t rsp
);
	import tef_pkg::*;

	localparam int STEP_W = $clog2(DIV_W);

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	logic [DIV_W-1:0]  num_q;
	logic [DVS_W-1:0]  rem_q;
	logic [DVS_W-1:0]  dvs_q;
	logic [DVS_W:0]    trial;
	logic              fits;

	assign trial = {rem_q, num_q[DIV_W-1]};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= STEP_W'(DIV_W - 1);
			end else if (busy_q) begin
				step_q <= step_q - 1'b1;
				if (step_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= req.dividend;
			dvs_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[DIV_W-2:0], fits};
			rem_q <= fits ? DVS_W'(trial - {1'b0, dvs_q}) : trial[DVS_W-1:0];
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = num_q;
endmodule

### hw/rtl/tef_checker.sv
// ----------------------------------------------------------------------------
// Touchpad event filter checker
// Port-level properties of the filter, bound to the top level.
// ----------------------------------------------------------------------------
`include "touchpad_event_filter_assert.svh"

module tef_checker (
	input logic clk,
	input logic arst_n,
	input logic ev_valid,
	input logic ev_ready,
	input logic res_valid,
	input logic res_ready,
	input logic res_last
);
	// A request is worked on alone, so the block is busy right after taking one.
	`TEF_ASSERT_NEXT(a_busy_after_req, ev_valid && ev_ready, !ev_ready, "ready after request")
	// The second result of a request follows the first without a gap.
	`TEF_ASSERT_NEXT(a_pair_follows, res_valid && res_ready && !res_last, res_valid, "gap in pair")
	// Nothing new is taken while a first result of a pair is stalled.
	`TEF_ASSERT_NOW(a_no_req_mid_pair, res_valid && !res_last, !ev_ready, "request mid pair")
	// A stalled result stays offered.
	`TEF_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid, "result dropped")
endmodule

bind touchpad_event_filter tef_checker u_tef_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.ev_valid  (ev.valid),
	.ev_ready  (ev.ready),
	.res_valid (res.valid),
	.res_ready (res.ready),
	.res_last  (res.out_last)
);

### tb/tb_touchpad_event_filter.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Touchpad event filter testbench
// Sends directed and random touchpad event streams through the filter, with
// random gaps on both channels. A cycle-free predictor of slot tracking,
// two-finger scroll and one-finger smoothing checks every result in order.
// ----------------------------------------------------------------------------
module tb_touchpad_event_filter;
	import tef_pkg::*;

	typedef struct packed {
		logic [15:0] typ;
		logic [15:0] code;
		logic [31:0] value;
		logic        last;
	} filt_ev_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	tef_ev_if ev_ch();
	tef_res_if res_ch();

	touchpad_event_filter u_top (
		.clk(clk),
		.arst_n(arst_n),
		.ev(ev_ch),
		.res(res_ch),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Results still owed by the filter, oldest first.
	filt_ev_t pending_events[$];
	filt_ev_t step_events[$];
	int mismatches = 0;
	int sent_count = 0;
	// When set, neither side idles; this gives back-to-back stretches.
	bit no_idle = 1'b0;

	// Predictor copy of the register file.
	bit pass_en;
	bit cal_en;
	int dz_lim, small_lim, medium_lim, lift_lim, scroll_lim;

	// Predictor copy of the tracking state.
	bit slot_on[SLOT_COUNT];
	int slot_y[SLOT_COUNT];
	int cur_slot, fingers, prior_fingers, settled;
	bit ref_ok;
	int ref_y;
	longint unsigned smoothed_q[2];
	bit axis_on[2];
	int raw_last[2];
	int step_last[2];

	function automatic int clamp_pos(int v);
		return (v < 0) ? 0 : ((v > 65535) ? 65535 : v);
	endfunction

	function automatic int iabs(int v);
		return (v < 0) ? -v : v;
	endfunction

	function automatic bit is_mt_code(logic [15:0] c);
		return c == C_MT_SLOT || c == C_MT_TRACK || c == C_MT_PX || c == C_MT_PY ||
			c == C_MT_MAJOR || c == C_MT_MINOR || c == C_MT_PRESS;
	endfunction

	// Appends a result of the current request; only the newest one is last.
	task automatic emit(logic [15:0] t, logic [15:0] c, logic [31:0] v);
		filt_ev_t e;
		if (step_events.size() > 0) begin
			step_events[step_events.size() - 1].last = 1'b0;
		end
		e.typ = t;
		e.code = c;
		e.value = v;
		e.last = 1'b1;
		step_events.push_back(e);
	endtask

	task automatic clear_axes();
		for (int i = 0; i < 2; i++) begin
			smoothed_q[i] = 0;
			axis_on[i] = 1'b0;
			raw_last[i] = 0;
			step_last[i] = 0;
		end
	endtask

	task automatic reset_model();
		pass_en = 1'b1;
		cal_en = 1'b0;
		dz_lim = 2;
		small_lim = 10;
		medium_lim = 25;
		lift_lim = 15;
		scroll_lim = 3;
		for (int i = 0; i < SLOT_COUNT; i++) begin
			slot_on[i] = 1'b0;
			slot_y[i] = 0;
		end
		cur_slot = 0;
		fingers = 0;
		prior_fingers = 0;
		settled = 0;
		ref_ok = 1'b0;
		ref_y = 0;
		clear_axes();
	endtask

	// Two-finger scroll: the mean Y of the busy slots is compared with the
	// previous mean, and a large enough change turns into a wheel step.
	task automatic scroll_step();
		int unsigned sum;
		int unsigned n;
		int avg, d, a, amt;
		sum = 0;
		n = 0;
		for (int i = 0; i < SLOT_COUNT; i++) begin
			if (slot_on[i]) begin
				sum += slot_y[i];
				n++;
			end
		end
		if (n == 0) begin
			return;
		end
		avg = sum / n;
		if (ref_ok) begin
			d = avg - ref_y;
			a = iabs(d);
			if (a > scroll_lim) begin
				amt = (a * 3 + 5) / 10;
				if (d > 0) begin
					amt = -amt;
				end
				if (amt != 0) begin
					emit(T_REL, C_WHEEL, amt);
					emit(T_SYN, C_REPORT, 32'd0);
				end
			end
		end
		ref_y = avg;
		ref_ok = 1'b1;
	endtask

	// One-finger path: deadzone, lift-noise rejection, then a three-band
	// exponential average held in Q16.8.
	task automatic smooth_step(logic [15:0] code, int pos);
		int ax, d, a, pa;
		longint unsigned w;
		ax = (code == C_ABS_X || code == C_MT_PX) ? 0 : 1;
		if (!axis_on[ax]) begin
			axis_on[ax] = 1'b1;
			smoothed_q[ax] = longint'(pos) << FRAC_BITS;
			raw_last[ax] = pos;
			emit(T_ABS, code, pos);
			return;
		end
		d = pos - raw_last[ax];
		a = iabs(d);
		pa = iabs(step_last[ax]);
		if (a < dz_lim) begin
			return;
		end
		if (a > lift_lim && pa < small_lim) begin
			return;
		end
		if (a < small_lim) begin
			w = 77;
		end else if (a < medium_lim) begin
			w = 154;
		end else begin
			w = 218;
		end
		smoothed_q[ax] = (w * (longint'(pos) << FRAC_BITS) + (256 - w) * smoothed_q[ax]
			+ 128) >> FRAC_BITS;
		raw_last[ax] = pos;
		step_last[ax] = d;
		emit(T_ABS, code, 32'((smoothed_q[ax] + 128) >> FRAC_BITS));
	endtask

	task automatic abs_step(logic [15:0] code, int val);
		if (code == C_MT_SLOT) begin
			cur_slot = (val < 0) ? 0 : ((val >= SLOT_COUNT) ? SLOT_COUNT - 1 : val);
		end else if (code == C_MT_TRACK) begin
			if (val == -1) begin
				if (slot_on[cur_slot]) begin
					fingers--;
				end
				slot_on[cur_slot] = 1'b0;
				if (fingers == 0) begin
					ref_ok = 1'b0;
				end
			end else begin
				if (!slot_on[cur_slot]) begin
					fingers++;
				end
				slot_on[cur_slot] = 1'b1;
			end
		end else if (code == C_MT_PY) begin
			slot_y[cur_slot] = clamp_pos(val);
			if (settled == 2) begin
				scroll_step();
				return;
			end
		end
		if (settled >= 2) begin
			if (!is_mt_code(code)) begin
				emit(T_ABS, code, val);
			end
		end else if ((code == C_ABS_X || code == C_ABS_Y || code == C_MT_PX ||
			code == C_MT_PY) && settled == 1) begin
			smooth_step(code, clamp_pos(val));
		end else begin
			emit(T_ABS, code, val);
		end
	endtask

	// Works out the results of one accepted request and queues them.
	task automatic predict_filter(logic [15:0] t, logic [15:0] c, logic signed [31:0] v);
		step_events.delete();
		if (t == T_SYN && c == C_REPORT) begin
			if (fingers != prior_fingers) begin
				ref_ok = 1'b0;
				prior_fingers = fingers;
			end
			settled = fingers;
		end
		if (pass_en) begin
			if (t == T_KEY) begin
				if (v == 0 && c == C_BTN_TOUCH) begin
					clear_axes();
				end
				emit(t, c, v);
			end else if (t == T_REL) begin
				if (c == C_REL_X || c == C_REL_Y) begin
					emit(t, c, cal_en ? ((v == -1) ? 32'd0 : v + 32'd1) : v);
				end
			end else if (t == T_ABS) begin
				abs_step(c, v);
			end else begin
				emit(t, c, v);
			end
		end
		foreach (step_events[i]) begin
			pending_events.push_back(step_events[i]);
		end
	endtask

	// Sends one request after a random gap and predicts it once accepted.
	task automatic send_event(logic [15:0] t, logic [15:0] c, logic signed [31:0] v);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			ev_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		ev_ch.valid <= 1'b1;
		ev_ch.ev_type <= t;
		ev_ch.ev_code <= c;
		ev_ch.ev_value <= v;
		do @(posedge clk); while (!ev_ch.ready);
		predict_filter(t, c, v);
		sent_count++;
	endtask

	// Waits until all results are in, then lets an event with no result
	// (the longest being a two-finger update) finish inside the block.
	task automatic wait_idle();
		ev_ch.valid <= 1'b0;
		while (pending_events.size() != 0) @(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] data);
		wait_idle();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_PASSTHROUGH: pass_en = data[0];
			CFG_CALIBRATION: cal_en = data[0];
			CFG_DEADZONE:    dz_lim = data;
			CFG_SMALL_MOVE:  small_lim = data;
			CFG_MEDIUM_MOVE: medium_lim = data;
			CFG_LIFT_JUMP:   lift_lim = data;
			CFG_SCROLL_MIN:  scroll_lim = data;
			default: ;
		endcase
	endtask

	task automatic write_all_regs(bit pass, bit cal, logic [7:0] dz, logic [7:0] sm,
		logic [7:0] md, logic [7:0] lj, logic [7:0] sc);
		write_reg(CFG_PASSTHROUGH, pass);
		write_reg(CFG_CALIBRATION, cal);
		write_reg(CFG_DEADZONE, dz);
		write_reg(CFG_SMALL_MOVE, sm);
		write_reg(CFG_MEDIUM_MOVE, md);
		write_reg(CFG_LIFT_JUMP, lj);
		write_reg(CFG_SCROLL_MIN, sc);
	endtask

	// Result side: random stalls after each accepted result, and the check.
	int stall_left = 0;
	always @(posedge clk) begin
		int n;
		filt_ev_t want;
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
			stall_left <= 0;
		end else begin
			if (res_ch.valid && res_ch.ready) begin
				if (pending_events.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("unexpected result: type %h code %h value %h last %b",
							res_ch.out_type, res_ch.out_code, res_ch.out_value,
							res_ch.out_last);
					end
				end else begin
					want = pending_events.pop_front();
					if (res_ch.out_type !== want.typ || res_ch.out_code !== want.code ||
						res_ch.out_value !== want.value || res_ch.out_last !== want.last) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("result mismatch: expected %h/%h/%h/%b got %h/%h/%h/%b",
								want.typ, want.code, want.value, want.last,
								res_ch.out_type, res_ch.out_code, res_ch.out_value,
								res_ch.out_last);
						end
					end
				end
			end
			if (stall_left != 0) begin
				stall_left <= stall_left - 1;
				res_ch.ready <= 1'b0;
			end else if (res_ch.valid && res_ch.ready) begin
				n = no_idle ? 0 : $urandom_range(0, 5);
				if (n != 0) begin
					stall_left <= n - 1;
					res_ch.ready <= 1'b0;
				end
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	// Directed checks of the pass-through paths and field extremes.
	task automatic test_pass_paths();
		send_event(T_SYN, C_REPORT, 0);
		send_event(T_KEY, C_BTN_TOUCH, 1);
		send_event(T_KEY, C_BTN_TOUCH, 0);
		send_event(T_REL, C_REL_X, -1);
		send_event(T_REL, C_REL_Y, 32'h7FFFFFFF);
		send_event(T_REL, C_WHEEL, 5);
		send_event(T_MSC, 16'h0004, 32'h80000000);
		send_event(16'hFFFF, 16'hFFFF, -1);
		send_event(T_ABS, C_MT_SLOT, -5);
		send_event(T_ABS, C_MT_SLOT, 20);
		send_event(T_ABS, C_ABS_X, 32'h7FFFFFFF);
		write_reg(CFG_CALIBRATION, 1'b1);
		send_event(T_REL, C_REL_X, -1);
		send_event(T_REL, C_REL_Y, 32'h7FFFFFFF);
		send_event(T_REL, C_REL_X, 32'hFFFFFFFE);
		write_reg(CFG_CALIBRATION, 1'b0);
	endtask

	// Directed one-finger smoothing, out-of-range positions and scroll cases.
	task automatic test_touch_cases();
		send_event(T_ABS, C_MT_SLOT, 0);
		send_event(T_ABS, C_MT_TRACK, 7);
		send_event(T_SYN, C_REPORT, 0);
		send_event(T_ABS, C_MT_PX, -100);
		send_event(T_ABS, C_MT_PX, 1);
		send_event(T_ABS, C_MT_PX, 20);
		send_event(T_ABS, C_MT_PX, 5);
		send_event(T_ABS, C_ABS_Y, 70000);
		send_event(T_ABS, C_ABS_Y, 65500);
		send_event(T_ABS, C_ABS_Y, 65000);
		send_event(T_ABS, C_MT_SLOT, 1);
		send_event(T_ABS, C_MT_TRACK, 8);
		send_event(T_SYN, C_REPORT, 0);
		send_event(T_ABS, C_MT_PY, 1000);
		send_event(T_ABS, C_MT_PY, 1100);
		send_event(T_ABS, C_MT_PY, 900);
		send_event(T_ABS, C_ABS_X, 33);
		// Two settled fingers but no busy slot: the Y update is silent.
		send_event(T_ABS, C_MT_TRACK, -1);
		send_event(T_ABS, C_MT_SLOT, 0);
		send_event(T_ABS, C_MT_TRACK, -1);
		send_event(T_ABS, C_MT_PY, 500);
		send_event(T_SYN, C_REPORT, 0);
		send_event(T_KEY, C_BTN_TOUCH, 0);
	endtask

	// Random position step: mostly around the thresholds, sometimes large.
	function automatic int rand_step();
		int m;
		case ($urandom_range(0, 3))
			0: m = $urandom_range(0, 3);
			1: m = $urandom_range(4, 30);
			2: m = $urandom_range(30, 300);
			default: m = $urandom_range(0, 3000);
		endcase
		return $urandom_range(0, 1) ? m : -m;
	endfunction

	// A gesture: fingers land, move for a few frames and lift.
	task automatic run_gesture();
		int nf, frames;
		int px[4];
		int py[4];
		nf = $urandom_range(1, 3);
		frames = $urandom_range(2, 8);
		for (int i = 0; i < nf; i++) begin
			px[i] = $urandom_range(0, 65535);
			py[i] = $urandom_range(0, 65535);
			send_event(T_ABS, C_MT_SLOT, i);
			send_event(T_ABS, C_MT_TRACK, $urandom_range(0, 1000));
			send_event(T_ABS, C_MT_PX, px[i]);
			send_event(T_ABS, C_MT_PY, py[i]);
		end
		send_event(T_KEY, C_BTN_TOUCH, 1);
		send_event(T_SYN, C_REPORT, 0);
		for (int f = 0; f < frames; f++) begin
			for (int i = 0; i < nf; i++) begin
				px[i] += rand_step();
				py[i] += rand_step();
				if (nf > 1) begin
					send_event(T_ABS, C_MT_SLOT, i);
				end
				send_event(T_ABS, C_MT_PX, px[i]);
				send_event(T_ABS, C_MT_PY, py[i]);
			end
			if ($urandom_range(0, 2) == 0) begin
				send_event(T_ABS, C_ABS_X, px[0]);
				send_event(T_ABS, C_ABS_Y, py[0]);
			end
			if ($urandom_range(0, 5) == 0) begin
				send_event(T_REL, $urandom_range(0, 2), $urandom());
			end
			send_event(T_SYN, C_REPORT, 0);
		end
		for (int i = 0; i < nf; i++) begin
			send_event(T_ABS, C_MT_SLOT, i);
			send_event(T_ABS, C_MT_TRACK, -1);
		end
		send_event(T_KEY, C_BTN_TOUCH, 0);
		send_event(T_SYN, C_REPORT, 0);
	endtask

	// Noise: random fields of every width, biased toward known types.
	task automatic send_noise();
		logic [15:0] t, c;
		t = $urandom_range(0, 3) == 0 ? 16'($urandom()) : 16'($urandom_range(0, 4));
		case ($urandom_range(0, 3))
			0: c = 16'($urandom());
			1: c = 16'($urandom_range(0, 2));
			2: c = 16'($urandom_range(16'h2F, 16'h3A));
			default: c = C_BTN_TOUCH;
		endcase
		send_event(t, c, $urandom());
	endtask

	task automatic test_random(int target);
		while (sent_count < target) begin
			no_idle = ($urandom_range(0, 7) == 0);
			if ($urandom_range(0, 4) == 0) begin
				repeat ($urandom_range(1, 6)) send_noise();
			end else begin
				run_gesture();
			end
		end
		no_idle = 1'b0;
	endtask

	task automatic test_settings();
		// Extremes first, then random register values.
		write_all_regs(1'b1, 1'b1, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
		test_random(sent_count + 120);
		write_all_regs(1'b1, 1'b0, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
		test_random(sent_count + 120);
		write_all_regs(1'b0, 1'b1, 8'd2, 8'd10, 8'd25, 8'd15, 8'd3);
		test_random(sent_count + 60);
		for (int k = 0; k < 3; k++) begin
			write_all_regs(1'b1, $urandom_range(0, 1), $urandom_range(0, 8),
				$urandom_range(0, 40), $urandom_range(0, 80), $urandom_range(0, 60),
				$urandom_range(0, 20));
			test_random(sent_count + 120);
		end
		write_all_regs(1'b1, 1'b0, 8'd2, 8'd10, 8'd25, 8'd15, 8'd3);
	endtask

	initial begin
		ev_ch.valid = 1'b0;
		ev_ch.ev_type = '0;
		ev_ch.ev_code = '0;
		ev_ch.ev_value = '0;
		res_ch.ready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		reset_model();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_pass_paths();
		test_touch_cases();
		test_random(sent_count + 200);
		test_settings();
		test_random(sent_count + 100);
		ev_ch.valid <= 1'b0;
		while (pending_events.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

	// Watchdog, far above the slowest correct run.
	initial begin
		#5000000;
		$display("Mismatches found");
		$finish;
	end

endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/tef_pkg.sv
hw/rtl/tef_if.sv
hw/rtl/tef_div.sv
hw/rtl/touchpad_event_filter.sv
hw/rtl/tef_checker.sv
tb/tb_touchpad_event_filter.sv
